@@ sv/bf3_pkg.sv @@
// Shared types, constants and arithmetic helpers for the 3x3 box filter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bf3_pkg;

  localparam int PIX_W  = 16;          // one colour channel
  localparam int PX_W   = 3 * PIX_W;   // packed pixel {blue, green, red}
  localparam int SUM_W  = 20;          // nine 16-bit channels summed
  localparam int DIM_W  = 11;          // image_dim register
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam int MAX_DIM_DEFAULT = 1024;
  localparam int DIM_RESET       = 1024;

  localparam logic [ADDR_W-1:0] ADDR_IMAGE_DIM = 3'd0;

  // floor(s/3) = (s * RECIP3) >> 21 and floor(s/9) = (s * RECIP9) >> 23,
  // exact for every s below 2^20
  localparam logic [SUM_W-1:0] RECIP3 = 20'd699051;
  localparam logic [SUM_W-1:0] RECIP9 = 20'd932068;
  localparam int SHIFT3 = 21;
  localparam int SHIFT9 = 23;

  typedef enum logic [2:0] {
    DIV1 = 3'd0,
    DIV2 = 3'd1,
    DIV3 = 3'd2,
    DIV4 = 3'd3,
    DIV6 = 3'd4,
    DIV9 = 3'd5
  } div_code_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    div_code_t        div;
    logic             last;
  } sum_req_t;

  // neighbour count is rows x cols, each one to three
  function automatic div_code_t div_code(input logic [1:0] rows, input logic [1:0] cols);
    div_code_t d;
    unique case ({rows, cols})
      4'b0101:                    d = DIV1;
      4'b0110, 4'b1001:           d = DIV2;
      4'b0111, 4'b1101:           d = DIV3;
      4'b1010:                    d = DIV4;
      4'b1011, 4'b1110:           d = DIV6;
      4'b1111:                    d = DIV9;
      default:                    d = DIV1;
    endcase
    return d;
  endfunction

  // sum of the cells picked by row and column masks; cells[ri][ci]
  function automatic logic [SUM_W-1:0] masked_sum(input logic [2:0][2:0][PIX_W-1:0] cells,
                                                  input logic [2:0] rmask,
                                                  input logic [2:0] cmask);
    logic [2:0][SUM_W-1:0] rs;
    logic [SUM_W-1:0]      total;
    for (int i = 0; i < 3; i++) begin
      rs[i] = (cmask[0] ? SUM_W'(cells[i][0]) : '0)
            + (cmask[1] ? SUM_W'(cells[i][1]) : '0)
            + (cmask[2] ? SUM_W'(cells[i][2]) : '0);
    end
    total = (rmask[0] ? rs[0] : '0) + (rmask[1] ? rs[1] : '0) + (rmask[2] ? rs[2] : '0);
    return total;
  endfunction

  // truncated mean; one 20x20 multiply for the divisors 3, 6 and 9
  function automatic logic [PIX_W-1:0] mean_div(input logic [SUM_W-1:0] s, input div_code_t div);
    logic [SUM_W-1:0]   x;
    logic [SUM_W-1:0]   m;
    logic [2*SUM_W-1:0] p;
    logic [PIX_W-1:0]   q;
    x = (div == DIV6) ? (s >> 1) : s;
    m = (div == DIV9) ? RECIP9 : RECIP3;
    p = (2*SUM_W)'(x) * (2*SUM_W)'(m);
    unique case (div)
      DIV1:       q = s[PIX_W-1:0];
      DIV2:       q = s[PIX_W:1];
      DIV4:       q = s[PIX_W+1:2];
      DIV3, DIV6: q = p[SHIFT3 +: PIX_W];
      DIV9:       q = p[SHIFT9 +: PIX_W];
      default:    q = s[PIX_W-1:0];
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

@@ sv/box_filter_3x3_edge_average_top.sv @@
// 3x3 box filter over a square RGB raster stream, edge-aware averaging.
// Depends on bf3_pkg, bf3_line_store and bf3_mean.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------------
//   apb      | in        | psel/penable/pready| paddr, pwdata, prdata (image_dim at 0x0)
//   pixel in | in        | in_valid/in_stall  | in_red, in_green, in_blue
//   result   | out       | out_valid/out_stall| out_red/green/blue, out_row, out_col,
//            |           |                    | last_in_run
//
// One pixel per cycle unless a pixel with several results holds it: one that closes a row
// (row 1 on) gives two, and in the last row each pixel from column 1 gives two, the final
// one four; the single sum unit forms one result per cycle when the output does not stall.
// Reset clears the window and positions and sets image_dim to 1024 (capped at MAX_DIM);
// line stores are not cleared and are read only where already written.
// Output stall backs up through the sum and divide registers to in_stall.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_3x3_edge_average_top #(
  parameter int MAX_DIM = bf3_pkg::MAX_DIM_DEFAULT,
  localparam int POS_W = $clog2(MAX_DIM)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bf3_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [bf3_pkg::DATA_W-1:0]    pwdata,
  output logic      [bf3_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bf3_pkg::PIX_W-1:0]     in_red,
  input  wire logic [bf3_pkg::PIX_W-1:0]     in_green,
  input  wire logic [bf3_pkg::PIX_W-1:0]     in_blue,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [bf3_pkg::PIX_W-1:0]     out_red,
  output logic      [bf3_pkg::PIX_W-1:0]     out_green,
  output logic      [bf3_pkg::PIX_W-1:0]     out_blue,
  output logic      [POS_W-1:0]              out_row,
  output logic      [POS_W-1:0]              out_col,
  output logic                               last_in_run
);
  import bf3_pkg::*;

  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DW > DIM_W) ? DW : DIM_W;

  typedef struct packed {
    logic up;        // row above exists
    logic up2;       // two rows above exist
    logic row_last;
    logic left;
    logic left2;
    logic col_last;
  } pos_flags_t;

  // ---------------- configuration ----------------
  logic [DIM_W-1:0] dim;
  logic [DIM_W-1:0] dim_next;
  logic [DIM_W-1:0] wr_val;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign prdata = DATA_W'(dim);
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_IMAGE_DIM);
  assign wr_val = pwdata[DIM_W-1:0];

  always_comb begin
    if (wr_val == '0) begin
      dim_next = DIM_W'(1);
    end else if (CMP_W'(wr_val) > CMP_W'(MAX_DIM)) begin
      dim_next = DIM_W'(MAX_DIM);
    end else begin
      dim_next = wr_val;
    end
  end

  // ---------------- input position ----------------
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_pos;
  logic             in_accept;
  pos_flags_t       flags_in;
  logic [PX_W-1:0]  cur_in;

  assign in_accept = in_valid && !in_stall;
  assign cur_in    = {in_blue, in_green, in_red};

  always_comb begin
    flags_in.up       = row_pos != '0;
    flags_in.up2      = CMP_W'(row_pos) >= CMP_W'(2);
    flags_in.row_last = (CMP_W'(row_pos) + CMP_W'(1)) == CMP_W'(dim);
    flags_in.left     = col_pos != '0;
    flags_in.left2    = CMP_W'(col_pos) >= CMP_W'(2);
    flags_in.col_last = (CMP_W'(col_pos) + CMP_W'(1)) == CMP_W'(dim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim     <= DIM_W'((DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET);
      row_pos <= '0;
      col_pos <= '0;
    end else if (cfg_wr) begin
      dim     <= dim_next;
      row_pos <= '0;
      col_pos <= '0;
    end else if (in_accept) begin
      if (flags_in.col_last) begin
        col_pos <= '0;
        row_pos <= flags_in.row_last ? '0 : row_pos + 1'b1;
      end else begin
        col_pos <= col_pos + 1'b1;
      end
    end
  end

  // ---------------- line stores ----------------
  logic [PX_W-1:0] up2_q;
  logic [PX_W-1:0] up1_q;

  bf3_line_store #(
    .DEPTH (MAX_DIM)
  ) u_line_store (
    .clk     (clk),
    .en      (in_accept),
    .par     (row_pos[0]),
    .addr    (col_pos),
    .wdata   (cur_in),
    .same_q  (up2_q),
    .other_q (up1_q)
  );

  // ---------------- pixel stage and result sequencer ----------------
  logic             s1_valid;
  logic [PX_W-1:0]  s1_cur;
  logic [POS_W-1:0] s1_row;
  logic [POS_W-1:0] s1_col;
  pos_flags_t       s1_f;
  logic             s1_rsel;   // 0: row above, 1: this row
  logic             s1_csel;   // 0: column left, 1: this column

  logic             has_res;
  logic             more_col;
  logic             more_row;
  logic             done;
  logic             step;
  logic             retire;
  logic             s2_ready;

  assign has_res  = (s1_f.up || s1_f.row_last) && (s1_f.left || s1_f.col_last);
  assign more_col = !s1_csel && s1_f.col_last;
  assign more_row = !s1_rsel && s1_f.row_last;
  assign done     = !has_res || !(more_col || more_row);
  assign step     = s1_valid && (!has_res || s2_ready);
  assign retire   = step && done;
  assign in_stall = s1_valid && !retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (retire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cur  <= cur_in;
      s1_row  <= row_pos;
      s1_col  <= col_pos;
      s1_f    <= flags_in;
      s1_rsel <= !flags_in.up;
      s1_csel <= !flags_in.left;
    end else if (step && !done) begin
      if (more_col) begin
        s1_csel <= 1'b1;
      end else begin
        s1_rsel <= 1'b1;
        s1_csel <= !s1_f.left;
      end
    end
  end

  // window of the two previous columns, rows R-2..R
  logic [5:0][PX_W-1:0] win;
  logic [PX_W-1:0]      up2_m;
  logic [PX_W-1:0]      up1_m;

  assign up2_m = s1_f.up2 ? up2_q : '0;
  assign up1_m = s1_f.up  ? up1_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (retire) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= up2_m;
      win[1] <= up1_m;
      win[2] <= s1_cur;
    end
  end

  logic [2:0][2:0][PX_W-1:0]  grid;
  logic [2:0][2:0][PIX_W-1:0] cells_r;
  logic [2:0][2:0][PIX_W-1:0] cells_g;
  logic [2:0][2:0][PIX_W-1:0] cells_b;
  logic [2:0]                 rmask;
  logic [2:0]                 cmask;
  logic [1:0]                 rcount;
  logic [1:0]                 ccount;
  sum_req_t                   req_next;

  always_comb begin
    grid[0][0] = win[3]; grid[0][1] = win[0]; grid[0][2] = up2_m;
    grid[1][0] = win[4]; grid[1][1] = win[1]; grid[1][2] = up1_m;
    grid[2][0] = win[5]; grid[2][1] = win[2]; grid[2][2] = s1_cur;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cells_r[i][j] = grid[i][j][0 +: PIX_W];
        cells_g[i][j] = grid[i][j][PIX_W +: PIX_W];
        cells_b[i][j] = grid[i][j][2*PIX_W +: PIX_W];
      end
    end
  end

  // bit 2 is the newest row / column; the far side drops out at the image edge
  assign rmask  = s1_rsel ? {1'b1, s1_f.up, 1'b0}   : {1'b1, 1'b1, s1_f.up2};
  assign cmask  = s1_csel ? {1'b1, s1_f.left, 1'b0} : {1'b1, 1'b1, s1_f.left2};
  assign rcount = {1'b0, rmask[0]} + {1'b0, rmask[1]} + {1'b0, rmask[2]};
  assign ccount = {1'b0, cmask[0]} + {1'b0, cmask[1]} + {1'b0, cmask[2]};

  always_comb begin
    req_next.red   = masked_sum(cells_r, rmask, cmask);
    req_next.green = masked_sum(cells_g, rmask, cmask);
    req_next.blue  = masked_sum(cells_b, rmask, cmask);
    req_next.div   = div_code(rcount, ccount);
    req_next.last  = done;
  end

  // ---------------- sum stage ----------------
  logic             s2_valid;
  sum_req_t         s2_req;
  logic [POS_W-1:0] s2_row;
  logic [POS_W-1:0] s2_col;
  logic             s3_ready;

  assign s2_ready = !s2_valid || s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid && has_res) begin
      s2_req <= req_next;
      s2_row <= s1_rsel ? s1_row : s1_row - 1'b1;
      s2_col <= s1_csel ? s1_col : s1_col - 1'b1;
    end
  end

  // ---------------- divide and output ----------------
  bf3_mean #(
    .POS_W (POS_W)
  ) u_mean (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (s2_valid),
    .req         (s2_req),
    .req_row     (s2_row),
    .req_col     (s2_col),
    .ready       (s3_ready),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_in_run (last_in_run)
  );

`ifndef ASSERT_OFF
  // a sum request blocked by the divide stage is neither lost nor altered
  ap_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s3_ready |=> s2_valid && $stable(s2_req))
    else $error("sum request changed while stalled");

  // the input position never leaves the image
  ap_pos_inside: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(row_pos) < CMP_W'(dim) && CMP_W'(col_pos) < CMP_W'(dim))
    else $error("input position outside image");

  // a pixel with results still to give keeps its stage
  ap_multi_stays: assert property (@(posedge clk) disable iff (rst)
    step && !done |=> s1_valid && $stable(s1_cur))
    else $error("pixel left before all its results");

  // a pixel without results never holds off the next request
  ap_zero_free: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !has_res |-> !in_stall)
    else $error("stall on a pixel without results");
`endif

endmodule

`default_nettype wire

@@ sv/bf3_line_store.sv @@
// Two line stores, one per row parity, with registered reads.
// Depends on bf3_pkg for the pixel width and the default depth.
`timescale 1ns / 1ps
`default_nettype none

module bf3_line_store #(
  parameter int DEPTH = bf3_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic                       par,
  input  wire logic [$clog2(DEPTH)-1:0]   addr,
  input  wire logic [bf3_pkg::PX_W-1:0]   wdata,
  output logic      [bf3_pkg::PX_W-1:0]   same_q,
  output logic      [bf3_pkg::PX_W-1:0]   other_q
);
  import bf3_pkg::*;

  logic [PX_W-1:0] bank0 [DEPTH];
  logic [PX_W-1:0] bank1 [DEPTH];
  logic [PX_W-1:0] q0;
  logic [PX_W-1:0] q1;
  logic            par_q;

  // read before write: the same-parity bank returns the row two above
  always_ff @(posedge clk) begin
    if (en) begin
      q0 <= bank0[addr];
      if (!par) begin
        bank0[addr] <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1 <= bank1[addr];
      if (par) begin
        bank1[addr] <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par_q <= par;
    end
  end

  assign same_q  = par_q ? q1 : q0;
  assign other_q = par_q ? q0 : q1;

endmodule

`default_nettype wire

@@ sv/bf3_mean.sv @@
// Divide stage and output register: turns channel sums into truncated means.
// Depends on bf3_pkg for sum_req_t and mean_div.
`timescale 1ns / 1ps
`default_nettype none

module bf3_mean #(
  parameter int POS_W = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  input  wire bf3_pkg::sum_req_t         req,
  input  wire logic [POS_W-1:0]          req_row,
  input  wire logic [POS_W-1:0]          req_col,
  output logic                           ready,
  input  wire logic                      out_stall,
  output logic                           out_valid,
  output logic [bf3_pkg::PIX_W-1:0]      out_red,
  output logic [bf3_pkg::PIX_W-1:0]      out_green,
  output logic [bf3_pkg::PIX_W-1:0]      out_blue,
  output logic [POS_W-1:0]               out_row,
  output logic [POS_W-1:0]               out_col,
  output logic                           last_in_run
);
  import bf3_pkg::*;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && req_valid) begin
      out_red     <= mean_div(req.red, req.div);
      out_green   <= mean_div(req.green, req.div);
      out_blue    <= mean_div(req.blue, req.div);
      out_row     <= req_row;
      out_col     <= req_col;
      last_in_run <= req.last;
    end
  end

endmodule

`default_nettype wire
